### src/csc_pkg.sv
// ---------------------------------------------------------------------------
// csc_pkg
// Shared types, event codes and bracket helpers for the comment checker.
// ---------------------------------------------------------------------------
package csc_pkg;

  // Event codes carried in the result request
  typedef enum logic [3:0] {
    EV_NULL             = 4'd0,
    EV_CONTROL          = 4'd1,
    EV_UNMATCHED        = 4'd2,
    EV_MISMATCH         = 4'd3,
    EV_TOO_LONG         = 4'd4,
    EV_UNCLOSED_BRACKET = 4'd5,
    EV_UNCLOSED_QUOTE   = 4'd6,
    EV_OVERFLOW         = 4'd7,
    EV_VERDICT          = 4'd8
  } event_e;

  // Bracket kind as held on the stack
  typedef enum logic [1:0] {
    KIND_BRACE = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_ROUND = 2'd2
  } kind_e;

  localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_BACKSLASH    = 8'h5C;
  localparam logic [7:0] CH_SQUOTE       = 8'h27;
  localparam logic [7:0] CH_DQUOTE       = 8'h22;
  localparam logic [7:0] CH_TAB          = 8'h09;
  localparam logic [7:0] CH_LF           = 8'h0A;
  localparam logic [7:0] CH_CR           = 8'h0D;
  localparam logic [7:0] CH_DEL          = 8'h7F;
  localparam logic [7:0] CH_SPACE        = 8'h20;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

  // Commands from controller to datapath
  typedef struct packed {
    logic   load;   // latch an accepted input request
    logic   emit;   // load the result register with event 'code'
    event_e code;
    logic   apply;  // commit the byte's stack, quote and count update
    logic   pop;    // drop the top stack entry (end-of-text drain)
    logic   clear;  // return comment state to its reset values
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic   null_pend;
    logic   ctrl_pend;
    logic   brk_ev;
    event_e brk_code;
    logic   end_pend;
    logic   too_long;
    logic   stack_nonempty;
    logic   quote_open;
    logic   out_free;
  } sts_t;

  function automatic logic [7:0] open_char(input kind_e k);
    logic [7:0] c;
    unique case (k)
      KIND_BRACE:  c = CH_OPEN_BRACE;
      KIND_SQUARE: c = CH_OPEN_SQUARE;
      default:     c = CH_OPEN_ROUND;
    endcase
    return c;
  endfunction

  function automatic logic is_control(input logic [7:0] c);
    return ((c < CH_SPACE) || (c == CH_DEL)) &&
           (c != CH_TAB) && (c != CH_LF) && (c != CH_CR);
  endfunction

endpackage

### src/csc_datapath.sv
// ---------------------------------------------------------------------------
// csc_datapath
// Bracket stack, quote tracking, byte count, length register and result register.
// ---------------------------------------------------------------------------
module csc_datapath #(
  parameter int unsigned STACK_DEPTH   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_has_i,
  input  logic                     in_end_i,
  input  csc_pkg::cmd_t            cmd_i,
  output csc_pkg::sts_t            sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output csc_pkg::event_e          out_code_o,
  output logic [POSITION_BITS-1:0] out_pos_o,
  output logic [7:0]               out_open_o,
  output logic [7:0]               out_close_o,
  output logic                     out_warn_o,
  output logic                     out_cvalid_o,
  output logic                     out_last_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CMP_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  logic [7:0]               byte_q;
  logic                     has_q, end_q, null_pend_q, ctrl_pend_q;
  csc_pkg::kind_e           kinds_q [STACK_DEPTH];
  logic [POSITION_BITS-1:0] pos_mem_q [STACK_DEPTH];
  logic [CNT_W-1:0]         cnt_q;
  logic                     sq_q, dq_q, odd_q, err_q;
  logic [POSITION_BITS-1:0] bcnt_q;
  logic [15:0]              maxlen_q;

  logic                     out_valid_q;
  csc_pkg::event_e          out_code_q;
  logic [POSITION_BITS-1:0] out_pos_q;
  logic [7:0]               out_open_q, out_close_q;
  logic                     out_warn_q, out_cvalid_q, out_last_q;

  logic [IDX_W-1:0]         top_idx;
  csc_pkg::kind_e           top_kind, byte_kind;
  logic [POSITION_BITS-1:0] top_pos;
  logic                     is_open, is_close, full, empty;
  logic                     brk_ev;
  csc_pkg::event_e          brk_code;

  logic [POSITION_BITS-1:0] ev_pos;
  logic [7:0]               ev_open, ev_close;
  logic                     ev_warn, ev_cvalid, ev_last;

  assign top_idx  = IDX_W'(cnt_q - CNT_W'(1));
  assign top_kind = kinds_q[top_idx];
  assign top_pos  = pos_mem_q[top_idx];
  assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
  assign empty    = (cnt_q == '0);

  always_comb begin
    is_open   = 1'b0;
    is_close  = 1'b0;
    byte_kind = csc_pkg::KIND_ROUND;
    unique case (byte_q)
      csc_pkg::CH_OPEN_BRACE:   begin is_open  = 1'b1; byte_kind = csc_pkg::KIND_BRACE;  end
      csc_pkg::CH_OPEN_SQUARE:  begin is_open  = 1'b1; byte_kind = csc_pkg::KIND_SQUARE; end
      csc_pkg::CH_OPEN_ROUND:   begin is_open  = 1'b1; byte_kind = csc_pkg::KIND_ROUND;  end
      csc_pkg::CH_CLOSE_BRACE:  begin is_close = 1'b1; byte_kind = csc_pkg::KIND_BRACE;  end
      csc_pkg::CH_CLOSE_SQUARE: begin is_close = 1'b1; byte_kind = csc_pkg::KIND_SQUARE; end
      csc_pkg::CH_CLOSE_ROUND:  begin is_close = 1'b1; byte_kind = csc_pkg::KIND_ROUND;  end
      default: ;
    endcase
  end

  always_comb begin
    brk_ev   = 1'b0;
    brk_code = csc_pkg::EV_MISMATCH;
    priority if (has_q && is_open && full) begin
      brk_ev   = 1'b1;
      brk_code = csc_pkg::EV_OVERFLOW;
    end else if (has_q && is_close && empty) begin
      brk_ev   = 1'b1;
      brk_code = csc_pkg::EV_UNMATCHED;
    end else if (has_q && is_close && (top_kind != byte_kind)) begin
      brk_ev   = 1'b1;
      brk_code = csc_pkg::EV_MISMATCH;
    end else begin
      brk_ev   = 1'b0;
    end
  end

  // Result fields for the event being emitted
  always_comb begin
    ev_pos    = '0;
    ev_open   = '0;
    ev_close  = '0;
    ev_warn   = 1'b0;
    ev_cvalid = 1'b0;
    ev_last   = 1'b0;
    unique case (cmd_i.code)
      csc_pkg::EV_NULL:      ev_pos = bcnt_q;
      csc_pkg::EV_CONTROL:   begin ev_pos = bcnt_q; ev_warn = 1'b1; end
      csc_pkg::EV_UNMATCHED: begin ev_pos = bcnt_q; ev_close = byte_q; end
      csc_pkg::EV_MISMATCH: begin
        ev_pos   = bcnt_q;
        ev_open  = csc_pkg::open_char(top_kind);
        ev_close = byte_q;
      end
      csc_pkg::EV_OVERFLOW:  begin ev_pos = bcnt_q; ev_open = byte_q; end
      csc_pkg::EV_UNCLOSED_BRACKET: begin
        ev_pos  = top_pos;
        ev_open = csc_pkg::open_char(top_kind);
      end
      csc_pkg::EV_VERDICT:   begin ev_cvalid = ~err_q; ev_last = 1'b1; end
      default: ;
    endcase
  end

  // Stack entries: no reset, only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && has_q && is_open && !full) begin
      kinds_q[cnt_q[IDX_W-1:0]]   <= byte_kind;
      pos_mem_q[cnt_q[IDX_W-1:0]] <= bcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q      <= '0;
      has_q       <= 1'b0;
      end_q       <= 1'b0;
      null_pend_q <= 1'b0;
      ctrl_pend_q <= 1'b0;
      cnt_q       <= '0;
      sq_q        <= 1'b0;
      dq_q        <= 1'b0;
      odd_q       <= 1'b0;
      bcnt_q      <= '0;
      err_q       <= 1'b0;
      maxlen_q    <= csc_pkg::MAX_LENGTH_RESET;
    end else begin
      if (cfg_we_i) begin
        maxlen_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        byte_q      <= in_byte_i;
        has_q       <= in_has_i;
        end_q       <= in_end_i;
        null_pend_q <= in_has_i && (in_byte_i == '0);
        ctrl_pend_q <= in_has_i && csc_pkg::is_control(in_byte_i);
      end
      if (cmd_i.emit && (cmd_i.code == csc_pkg::EV_NULL)) begin
        null_pend_q <= 1'b0;
      end
      if (cmd_i.emit && (cmd_i.code == csc_pkg::EV_CONTROL)) begin
        ctrl_pend_q <= 1'b0;
      end
      if (cmd_i.emit && (cmd_i.code != csc_pkg::EV_CONTROL) &&
          (cmd_i.code != csc_pkg::EV_VERDICT)) begin
        err_q <= 1'b1;
      end
      if (cmd_i.apply && has_q) begin
        if (is_open && !full) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else if (is_close && !empty) begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
        if ((byte_q == csc_pkg::CH_DQUOTE) && !sq_q) begin
          if (!odd_q) dq_q <= ~dq_q;
        end else if ((byte_q == csc_pkg::CH_SQUOTE) && !dq_q) begin
          if (!odd_q) sq_q <= ~sq_q;
        end
        odd_q <= (byte_q == csc_pkg::CH_BACKSLASH) ? ~odd_q : 1'b0;
        if (bcnt_q != '1) begin
          bcnt_q <= bcnt_q + POSITION_BITS'(1);
        end
      end
      if (cmd_i.pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.clear) begin
        cnt_q  <= '0;
        sq_q   <= 1'b0;
        dq_q   <= 1'b0;
        odd_q  <= 1'b0;
        bcnt_q <= '0;
        err_q  <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_code_q   <= cmd_i.code;
      out_pos_q    <= ev_pos;
      out_open_q   <= ev_open;
      out_close_q  <= ev_close;
      out_warn_q   <= ev_warn;
      out_cvalid_q <= ev_cvalid;
      out_last_q   <= ev_last;
    end
  end

  always_comb begin
    sts_o.null_pend      = null_pend_q;
    sts_o.ctrl_pend      = ctrl_pend_q;
    sts_o.brk_ev         = brk_ev;
    sts_o.brk_code       = brk_code;
    sts_o.end_pend       = end_q;
    sts_o.too_long       = CMP_W'(bcnt_q) > CMP_W'(maxlen_q);
    sts_o.stack_nonempty = ~empty;
    sts_o.quote_open     = sq_q | dq_q;
    sts_o.out_free       = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_code_o   = out_code_q;
  assign out_pos_o    = out_pos_q;
  assign out_open_o   = out_open_q;
  assign out_close_o  = out_close_q;
  assign out_warn_o   = out_warn_q;
  assign out_cvalid_o = out_cvalid_q;
  assign out_last_o   = out_last_q;

endmodule

### src/csc_controller.sv
// ---------------------------------------------------------------------------
// csc_controller
// Sequencer that walks each request through its events, taking no new request until they are done.
// ---------------------------------------------------------------------------
module csc_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  csc_pkg::sts_t sts_i,
  output csc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_LEN,
    S_DRAIN,
    S_QUOTE,
    S_VERDICT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = 1'b0;
    cmd_o.code  = csc_pkg::EV_VERDICT;
    cmd_o.apply = 1'b0;
    cmd_o.pop   = 1'b0;
    cmd_o.clear = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_BYTE;
        end
      end
      S_BYTE: begin
        // null first, then control, then the bracket event with the update
        priority if (sts_i.null_pend) begin
          cmd_o.emit = sts_i.out_free;
          cmd_o.code = csc_pkg::EV_NULL;
        end else if (sts_i.ctrl_pend) begin
          cmd_o.emit = sts_i.out_free;
          cmd_o.code = csc_pkg::EV_CONTROL;
        end else if (!sts_i.brk_ev || sts_i.out_free) begin
          cmd_o.emit  = sts_i.brk_ev;
          cmd_o.code  = sts_i.brk_code;
          cmd_o.apply = 1'b1;
          state_d     = sts_i.end_pend ? S_LEN : S_IDLE;
        end
      end
      S_LEN: begin
        if (!sts_i.too_long || sts_i.out_free) begin
          cmd_o.emit = sts_i.too_long;
          cmd_o.code = csc_pkg::EV_TOO_LONG;
          state_d    = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.stack_nonempty) begin
          state_d = S_QUOTE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = csc_pkg::EV_UNCLOSED_BRACKET;
          cmd_o.pop  = 1'b1;
        end
      end
      S_QUOTE: begin
        if (!sts_i.quote_open || sts_i.out_free) begin
          cmd_o.emit = sts_i.quote_open;
          cmd_o.code = csc_pkg::EV_UNCLOSED_QUOTE;
          state_d    = S_VERDICT;
        end
      end
      S_VERDICT: begin
        if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.code  = csc_pkg::EV_VERDICT;
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/comment_syntax_checker.sv
// ---------------------------------------------------------------------------
// comment_syntax_checker
// Balanced bracket and quote checker for comment text, one byte a request.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tdata byte_value, tuser has_byte, tlast end_of_text
// m_axis    out        tdata event/position/brackets, tuser flags, tlast verdict
// cfg       in         cfg_wdata_i max_length, written when cfg_we_i is high
//
// Byte request: accept, then any null and control events, then the update;
// a bracket event leaves with the update. End of text adds the length
// check, the drain of each open bracket, the quote check and the verdict.
// Reset (rst_ni low, asynchronous) clears control state; stack entries are
// undefined until pushed. A stalled m_axis holds the sequencer; input is
// taken again once idle, even while the last result waits in the register.
//
module comment_syntax_checker #(
  parameter int unsigned STACK_DEPTH   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // cfg: max_length
  input  logic                                  cfg_we_i,
  input  logic [15:0]                           cfg_wdata_i,
  // s_axis tdata: [7:0] byte_value
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [7:0]                            s_axis_tdata_i,
  // s_axis tuser: [0] has_byte
  input  logic [0:0]                            s_axis_tuser_i,
  input  logic                                  s_axis_tlast_i,
  // m_axis tdata: event_code(4), position(POSITION_BITS), open_bracket(8),
  //               close_bracket(8), zero fill to whole bytes
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [((POSITION_BITS+27)/8)*8-1:0]   m_axis_tdata_o,
  // m_axis tuser: [0] is_warning, [1] comment_valid
  output logic [1:0]                            m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  localparam int unsigned TDATA_W = ((POSITION_BITS + 27) / 8) * 8;

  csc_pkg::cmd_t            cmd;
  csc_pkg::sts_t            sts;
  csc_pkg::event_e          out_code;
  logic [POSITION_BITS-1:0] out_pos;
  logic [7:0]               out_open, out_close;
  logic                     out_warn, out_cvalid;

  // Sequence each request's events
  csc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold stack, quote state, count and the result register
  csc_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_byte_i    (s_axis_tdata_i),
    .in_has_i     (s_axis_tuser_i[0]),
    .in_end_i     (s_axis_tlast_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_code_o   (out_code),
    .out_pos_o    (out_pos),
    .out_open_o   (out_open),
    .out_close_o  (out_close),
    .out_warn_o   (out_warn),
    .out_cvalid_o (out_cvalid),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack result fields, lowest field first, zero fill on top
  assign m_axis_tdata_o = TDATA_W'({out_close, out_open, out_pos, out_code});
  assign m_axis_tuser_o = {out_cvalid, out_warn};

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten while full");

  // The final result of a comment is always the verdict
  a_last_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (out_code == csc_pkg::EV_VERDICT))
    else $error("last flag on a non-verdict result");

  // Warning flag only on control-character events
  a_warn_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_warn) |-> (out_code == csc_pkg::EV_CONTROL))
    else $error("warning flag on a non-control event");

  // Comment-valid only on the verdict
  a_cvalid_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_cvalid) |-> m_axis_tlast_o)
    else $error("comment_valid outside the verdict");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the comment syntax checker: comment bytes stream
// in through s_axis, predicted events are compared field by field with the
// events on m_axis, across several max_length settings.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STACK_DEPTH   = 32;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned TDATA_W       = ((POSITION_BITS + 27) / 8) * 8;
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 12;
  localparam logic [15:0] POS_SAT       = 16'hFFFF;
  localparam logic [7:0]  CH_NUL        = 8'h00;
  localparam logic [7:0]  CH_UNIT_SEP   = 8'h1F;
  localparam logic [7:0]  CH_SOH        = 8'h01;
  localparam logic [7:0]  CH_HIGH_FIRST = 8'h80;
  localparam logic [7:0]  CH_HIGH_LAST  = 8'hFF;
  localparam logic [7:0]  CH_LOWER_A    = 8'h61;
  localparam logic [7:0]  CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0]  NO_BRACKET    = 8'h00;

  // One input request: a byte, its has_byte flag and the end-of-text mark
  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       eot;
  } text_req_t;

  // One checker event, field by field
  typedef struct {
    csc_pkg::event_e code;
    logic [15:0]     pos;
    logic [7:0]      ob;
    logic [7:0]      cb;
    logic            warn;
    logic            valid;
    logic            last;
  } chk_event_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [15:0]         cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data    = '0;
  logic [0:0]          s_user    = '0;
  logic                s_last    = 1'b0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [TDATA_W-1:0]  m_data;
  logic [1:0]          m_user;
  logic                m_last;

  comment_syntax_checker #(
    .STACK_DEPTH  (STACK_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Predictor state: a copy of the comment state, kept at the block's widths.
  // The stack holds the opening character itself rather than a kind code.
  // -------------------------------------------------------------------------
  logic [7:0]  open_ch  [STACK_DEPTH];
  logic [15:0] open_pos [STACK_DEPTH];
  int          depth;
  logic        in_sq;
  logic        in_dq;
  logic        esc_odd;
  logic [15:0] text_len;
  logic        error_flag;
  logic [15:0] max_len;

  text_req_t   pending_requests[$];
  chk_event_t  expected_events[$];
  int          mismatch_count = 0;
  int          cycle_cnt = 0;

  function automatic logic is_opener(input logic [7:0] c);
    return (c == csc_pkg::CH_OPEN_BRACE) || (c == csc_pkg::CH_OPEN_SQUARE) ||
           (c == csc_pkg::CH_OPEN_ROUND);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == csc_pkg::CH_CLOSE_BRACE) || (c == csc_pkg::CH_CLOSE_SQUARE) ||
           (c == csc_pkg::CH_CLOSE_ROUND);
  endfunction

  function automatic logic [7:0] closer_of(input logic [7:0] o);
    case (o)
      csc_pkg::CH_OPEN_BRACE:  return csc_pkg::CH_CLOSE_BRACE;
      csc_pkg::CH_OPEN_SQUARE: return csc_pkg::CH_CLOSE_SQUARE;
      default:                 return csc_pkg::CH_CLOSE_ROUND;
    endcase
  endfunction

  // Append one predicted event; any non-warning event other than the verdict
  // spoils the comment
  function automatic void add_event(input csc_pkg::event_e code,
                                    input logic [15:0] pos,
                                    input logic [7:0] ob, input logic [7:0] cb,
                                    input logic warn, input logic valid,
                                    input logic last);
    chk_event_t ev;
    ev.code  = code;
    ev.pos   = pos;
    ev.ob    = ob;
    ev.cb    = cb;
    ev.warn  = warn;
    ev.valid = valid;
    ev.last  = last;
    expected_events = {expected_events, ev};
    if (!warn && code != csc_pkg::EV_VERDICT) error_flag = 1'b1;
  endfunction

  function automatic void clear_comment_state();
    depth      = 0;
    in_sq      = 1'b0;
    in_dq      = 1'b0;
    esc_odd    = 1'b0;
    text_len   = '0;
    error_flag = 1'b0;
  endfunction

  // Work out every event that one accepted request raises
  function automatic void predict_events(input logic [7:0] b, input logic has,
                                         input logic eot);
    logic [7:0] top;
    logic       ctrl;
    if (has) begin
      ctrl = (b == csc_pkg::CH_DEL) ||
             (b < csc_pkg::CH_SPACE && b != csc_pkg::CH_TAB && b != csc_pkg::CH_LF &&
              b != csc_pkg::CH_CR);
      if (b == CH_NUL)
        add_event(csc_pkg::EV_NULL, text_len, NO_BRACKET, NO_BRACKET, 1'b0, 1'b0, 1'b0);
      if (ctrl)
        add_event(csc_pkg::EV_CONTROL, text_len, NO_BRACKET, NO_BRACKET, 1'b1, 1'b0, 1'b0);
      if (is_opener(b)) begin
        if (depth >= STACK_DEPTH) begin
          add_event(csc_pkg::EV_OVERFLOW, text_len, b, NO_BRACKET, 1'b0, 1'b0, 1'b0);
        end else begin
          open_ch[depth]  = b;
          open_pos[depth] = text_len;
          depth++;
        end
      end else if (is_closer(b)) begin
        if (depth == 0) begin
          add_event(csc_pkg::EV_UNMATCHED, text_len, NO_BRACKET, b, 1'b0, 1'b0, 1'b0);
        end else begin
          depth--;
          top = open_ch[depth];
          if (closer_of(top) != b)
            add_event(csc_pkg::EV_MISMATCH, text_len, top, b, 1'b0, 1'b0, 1'b0);
        end
      end
      // A quote escaped by an odd run of backslashes leaves the state alone
      if (b == csc_pkg::CH_DQUOTE && !in_sq) begin
        if (!esc_odd) in_dq = !in_dq;
      end else if (b == csc_pkg::CH_SQUOTE && !in_dq) begin
        if (!esc_odd) in_sq = !in_sq;
      end
      esc_odd = (b == csc_pkg::CH_BACKSLASH) ? !esc_odd : 1'b0;
      if (text_len != POS_SAT) text_len++;
    end
    if (eot) begin
      if (text_len > max_len)
        add_event(csc_pkg::EV_TOO_LONG, '0, NO_BRACKET, NO_BRACKET, 1'b0, 1'b0, 1'b0);
      while (depth > 0) begin
        depth--;
        add_event(csc_pkg::EV_UNCLOSED_BRACKET, open_pos[depth], open_ch[depth],
                  NO_BRACKET, 1'b0, 1'b0, 1'b0);
      end
      if (in_sq || in_dq)
        add_event(csc_pkg::EV_UNCLOSED_QUOTE, '0, NO_BRACKET, NO_BRACKET, 1'b0, 1'b0, 1'b0);
      add_event(csc_pkg::EV_VERDICT, '0, NO_BRACKET, NO_BRACKET, 1'b0, !error_flag, 1'b1);
      clear_comment_state();
    end
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // -------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps.
  // -------------------------------------------------------------------------
  int        burst_left = 0;
  int        gap_left   = 0;
  text_req_t next_req;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) predict_events(s_data, s_user[0], s_last);
      if (!s_valid || s_ready) begin
        if (pending_requests.size() != 0 && burst_left != 0) begin
          next_req = pending_requests.pop_front();
          s_data  <= next_req.data;
          s_user  <= next_req.has;
          s_last  <= next_req.eot;
          s_valid <= 1'b1;
          burst_left--;
        end else begin
          s_valid <= 1'b0;
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Long hold-off: once requested, keep m_axis stalled until hold_left runs out, so the
  // result register and sequencer back up and s_axis stops taking requests.
  // -------------------------------------------------------------------------
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: cycle through four stall patterns, one of them never stalling
  logic rx_ready;

  always @(posedge clk_i) begin
    case (cycle_cnt[8:7])
      2'd0:    rx_ready = 1'b1;
      2'd1:    rx_ready = 1'($urandom_range(0, 1));
      2'd2:    rx_ready = (cycle_cnt[1:0] == 2'd0);
      default: rx_ready = ($urandom_range(0, 7) != 0);
    endcase
    m_ready <= rx_ready && (hold_left == 0);
  end

  // -------------------------------------------------------------------------
  // Monitor: unpack each accepted result and compare with the oldest
  // prediction. tdata: [3:0] code, [19:4] position, [27:20] open bracket,
  // [35:28] close bracket; tuser: [0] warning, [1] comment valid.
  // -------------------------------------------------------------------------
  chk_event_t want;
  logic [3:0]  got_code;
  logic [15:0] got_pos;
  logic [7:0]  got_ob;
  logic [7:0]  got_cb;

  always @(posedge clk_i) begin
    if (rst_n && m_valid && m_ready) begin
      got_code = m_data[3:0];
      got_pos  = m_data[19:4];
      got_ob   = m_data[27:20];
      got_cb   = m_data[35:28];
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result code %0d pos %0d", got_code, got_pos));
      end else begin
        want = expected_events.pop_front();
        if (got_code != want.code)
          report_mismatch($sformatf("code %0d, want %0d", got_code, want.code));
        if (got_pos != want.pos)
          report_mismatch($sformatf("position %0d, want %0d (code %0d)",
                                    got_pos, want.pos, want.code));
        if (got_ob != want.ob)
          report_mismatch($sformatf("open bracket %h, want %h (code %0d)",
                                    got_ob, want.ob, want.code));
        if (got_cb != want.cb)
          report_mismatch($sformatf("close bracket %h, want %h (code %0d)",
                                    got_cb, want.cb, want.code));
        if (m_user[0] != want.warn)
          report_mismatch($sformatf("warning %b, want %b (code %0d)",
                                    m_user[0], want.warn, want.code));
        if (m_user[1] != want.valid)
          report_mismatch($sformatf("comment valid %b, want %b (code %0d)",
                                    m_user[1], want.valid, want.code));
        if (m_last != want.last)
          report_mismatch($sformatf("last %b, want %b (code %0d)",
                                    m_last, want.last, want.code));
      end
    end
  end

  // Watchdog: a hang or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL comment_syntax_checker");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  int queued_items = 0;

  task automatic queue_req(input logic [7:0] b, input logic has, input logic eot);
    text_req_t r;
    r.data = b;
    r.has  = has;
    r.eot  = eot;
    pending_requests = {pending_requests, r};
    if (has || eot) queued_items++;
  endtask

  // Queue a comment; the last byte carries the end mark unless end_only
  task automatic queue_text(input logic [7:0] text[$], input bit end_only);
    for (int i = 0; i < text.size(); i++)
      queue_req(text[i], 1'b1, (i == text.size() - 1) && !end_only);
    if (end_only || text.size() == 0) queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] any_opener();
    case ($urandom_range(0, 2))
      0:       return csc_pkg::CH_OPEN_BRACE;
      1:       return csc_pkg::CH_OPEN_SQUARE;
      default: return csc_pkg::CH_OPEN_ROUND;
    endcase
  endfunction

  function automatic logic [7:0] any_closer();
    case ($urandom_range(0, 2))
      0:       return csc_pkg::CH_CLOSE_BRACE;
      1:       return csc_pkg::CH_CLOSE_SQUARE;
      default: return csc_pkg::CH_CLOSE_ROUND;
    endcase
  endfunction

  // Weighted byte: brackets, quotes, escapes and control bytes turn up far
  // more often than a flat draw would give
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 7))
      0: return any_opener();
      1: return any_closer();
      2: begin
        case ($urandom_range(0, 2))
          0:       return csc_pkg::CH_SQUOTE;
          1:       return csc_pkg::CH_DQUOTE;
          default: return csc_pkg::CH_BACKSLASH;
        endcase
      end
      3: begin
        case ($urandom_range(0, 6))
          0:       return CH_NUL;
          1:       return CH_SOH;
          2:       return CH_UNIT_SEP;
          3:       return csc_pkg::CH_DEL;
          4:       return csc_pkg::CH_TAB;
          5:       return csc_pkg::CH_LF;
          default: return csc_pkg::CH_CR;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random comment. Clean ones keep brackets balanced and close them at
  // the end; the rest are noise. Ignored requests are sprinkled in.
  task automatic queue_random_comment(input int len, input bit clean);
    logic [7:0] text[$];
    logic [7:0] opens[$];
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (!clean) begin
        b = noisy_byte();
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            b = any_opener();
            opens = {opens, b};
          end
          2, 3: b = (opens.size() != 0) ? closer_of(opens.pop_back()) : csc_pkg::CH_SPACE;
          4:    b = ($urandom_range(0, 1) != 0) ? csc_pkg::CH_SQUOTE : csc_pkg::CH_DQUOTE;
          5:    b = csc_pkg::CH_BACKSLASH;
          default: b = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        endcase
      end
      text = {text, b};
    end
    while (opens.size() != 0) text = {text, closer_of(opens.pop_back())};
    // Slip an ignored request somewhere in front of the comment now and then
    if ($urandom_range(0, 5) == 0) queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    queue_text(text, $urandom_range(0, 7) == 0);
  endtask

  task automatic queue_random_phase(input int count);
    int target;
    target = queued_items + count;
    while (queued_items < target)
      queue_random_comment(int'($urandom_range(0, 14)), $urandom_range(0, 3) != 0);
  endtask

  // Wait until every request is taken and every event has come out, then
  // allow for a request that raises no event still being worked on
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_valid || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    max_len = v;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  logic [7:0] text[$];

  initial begin
    clear_comment_state();
    max_len = csc_pkg::MAX_LENGTH_RESET;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed part, run at the reset length limit.
    // Empty comment: an end-only request gives a clean verdict.
    queue_req(CH_HIGH_LAST, 1'b0, 1'b1);
    // Ignored request, no byte and no end mark
    queue_req(CH_HIGH_LAST, 1'b0, 1'b0);
    // Null, control bytes, the three exempt whitespace bytes, high bytes
    text = '{CH_NUL, CH_UNIT_SEP, csc_pkg::CH_DEL, csc_pkg::CH_TAB, csc_pkg::CH_LF,
             csc_pkg::CH_CR, CH_HIGH_FIRST, CH_HIGH_LAST};
    queue_text(text, 1'b0);
    // Mismatched and unmatched closers, a bracket left open, an escaped
    // single quote and a double quote inside single quotes
    text = '{csc_pkg::CH_OPEN_BRACE, csc_pkg::CH_OPEN_SQUARE, csc_pkg::CH_OPEN_ROUND,
             csc_pkg::CH_CLOSE_SQUARE, csc_pkg::CH_CLOSE_BRACE, csc_pkg::CH_CLOSE_ROUND,
             csc_pkg::CH_CLOSE_BRACE, csc_pkg::CH_OPEN_ROUND, csc_pkg::CH_SQUOTE,
             csc_pkg::CH_BACKSLASH, csc_pkg::CH_SQUOTE, csc_pkg::CH_DQUOTE};
    queue_text(text, 1'b0);
    // Even backslash run: the quote is live and stays open
    text = '{csc_pkg::CH_BACKSLASH, csc_pkg::CH_BACKSLASH, csc_pkg::CH_SQUOTE};
    queue_text(text, 1'b0);
    wait_idle();

    // Zero limit: every non-empty comment is too long
    write_max_length(16'd0);
    queue_random_phase(60);
    wait_idle();

    // Widest limit. Overflow the stack first: two pushes are dropped and
    // the closing end byte mismatches or pops its partner.
    write_max_length(16'hFFFF);
    text = {};
    for (int i = 0; i < STACK_DEPTH + 2; i++) text = {text, any_opener()};
    text = {text, any_closer()};
    queue_text(text, 1'b0);
    // Long receiver hold-off while the sender keeps offering
    hold_request = 1'b1;
    queue_random_phase(90);
    wait_idle();

    // Small limit near typical comment lengths
    write_max_length(16'($urandom_range(1, 20)));
    queue_random_phase(60);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS comment_syntax_checker");
    end else begin
      $display("FAIL comment_syntax_checker");
    end
    $finish;
  end

endmodule
